// File: sv/byte_ring_buffer_with_search_macros.svh
`ifndef BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, off while reset is high.
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: sv/brb_pkg.sv
package brb_pkg;

  localparam int DEPTH     = 4096;
  localparam int MAX_FETCH = 64;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int FETCH_W   = 7;
  localparam int LEN_W     = 13;
  localparam int BYTE_W    = 8;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_PEEK    = 3'd2,
    OP_FIND    = 3'd3,
    OP_CONSUME = 3'd4,
    OP_CLEAR   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FIND
  } seq_state_t;

endpackage

// File: sv/brb_ram.sv
module brb_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/byte_ring_buffer_with_search.sv
// Write, consume, clear, unused opcodes and empty read/peek/find: one result the
// cycle after start; the next item may be started in that same cycle.
// Read/peek of n bytes: n results, one per cycle, each from a registered RAM read; busy until the last.
// Find: at most one store read per stored byte through a single RAM port, ending at the
// first match or the last stored byte. Results cannot be stalled by the receiver.
// Synchronous reset empties the buffer and cancels any burst; store contents persist.
module byte_ring_buffer_with_search
  import brb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               burst_first,
  input  logic [LEN_W-1:0]   length,
  input  logic [FETCH_W-1:0] fetch_length,
  input  logic [PTR_W-1:0]   offset,
  output logic               strobe,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               byte_valid,
  output logic               ok,
  output logic [PTR_W-1:0]   position,
  output logic [CNT_W-1:0]   available,
  output logic               last
);

  `include "byte_ring_buffer_with_search_macros.svh"

  localparam logic [CNT_W-1:0]   DepthC = CNT_W'(DEPTH);
  localparam logic [FETCH_W-1:0] MaxFetchC = FETCH_W'(MAX_FETCH);

  seq_state_t state, state_next;

  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] fill;
  logic             burst_acc;
  logic [LEN_W-1:0] burst_rem;

  logic [PTR_W-1:0]  seq_addr;
  logic [CNT_W-1:0]  seq_left;
  logic [PTR_W-1:0]  seq_idx;
  logic [BYTE_W-1:0] delim;
  logic              pend;
  logic              pend_last;
  logic [PTR_W-1:0]  pend_idx;

  logic [BYTE_W-1:0] rdata;
  logic              accept, issue, match, find_stop;

  // accept-time next values
  logic [PTR_W-1:0]  wp_next, rp_next;
  logic [CNT_W-1:0]  fill_next;
  logic              burst_acc_next;
  logic [LEN_W-1:0]  burst_rem_next;
  logic              wr_en;
  logic              imm_res, imm_ok;
  logic              go_fetch, go_find;
  logic [PTR_W-1:0]  load_addr;
  logic [CNT_W-1:0]  load_left;
  logic [FETCH_W-1:0] fcap;
  logic [CNT_W-1:0]  room, take;

  assign accept = start && !busy;
  assign match  = (rdata == delim);

  // accept-time decode
  always_comb begin
    wp_next        = wp;
    rp_next        = rp;
    fill_next      = fill;
    burst_acc_next = burst_acc;
    burst_rem_next = burst_rem;
    wr_en          = 1'b0;
    imm_res        = 1'b1;
    imm_ok         = 1'b0;
    go_fetch       = 1'b0;
    go_find        = 1'b0;
    load_addr      = rp;
    load_left      = '0;
    fcap           = (fetch_length > MaxFetchC) ? MaxFetchC : fetch_length;
    room           = '0;
    take           = '0;
    case (opcode_t'(opcode))
      OP_WRITE: begin
        if (burst_first) begin
          if (length <= LEN_W'(DepthC - fill)) begin
            burst_acc_next = 1'b1;
            imm_ok         = 1'b1;
            if (length != '0) begin
              wr_en          = 1'b1;
              burst_rem_next = length - LEN_W'(1);
            end else begin
              burst_rem_next = '0;
            end
          end else begin
            burst_acc_next = 1'b0;
            burst_rem_next = '0;
          end
        end else if (burst_acc && burst_rem != '0) begin
          if (fill >= DepthC) begin
            burst_acc_next = 1'b0;
            burst_rem_next = '0;
          end else begin
            wr_en          = 1'b1;
            imm_ok         = 1'b1;
            burst_rem_next = burst_rem - LEN_W'(1);
          end
        end
        if (wr_en) begin
          wp_next   = wp + PTR_W'(1);
          fill_next = fill + CNT_W'(1);
        end
      end
      OP_READ: begin
        take = (CNT_W'(fcap) > fill) ? fill : CNT_W'(fcap);
        rp_next   = rp + take[PTR_W-1:0];
        fill_next = fill - take;
        load_addr = rp;
        load_left = take;
        if (take != '0) begin
          imm_res  = 1'b0;
          go_fetch = 1'b1;
        end
      end
      OP_PEEK: begin
        if (CNT_W'(offset) < fill) begin
          room = fill - CNT_W'(offset);
          take = (CNT_W'(fcap) > room) ? room : CNT_W'(fcap);
          load_addr = rp + offset;
          load_left = take;
          if (take != '0) begin
            imm_res  = 1'b0;
            go_fetch = 1'b1;
          end
        end
      end
      OP_FIND: begin
        load_left = fill;
        if (fill != '0) begin
          imm_res = 1'b0;
          go_find = 1'b1;
        end
      end
      OP_CONSUME: begin
        take = (length < LEN_W'(fill)) ? CNT_W'(length) : fill;
        rp_next   = rp + take[PTR_W-1:0];
        fill_next = fill - take;
      end
      OP_CLEAR: begin
        wp_next        = '0;
        rp_next        = '0;
        fill_next      = '0;
        burst_acc_next = 1'b0;
        burst_rem_next = '0;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && go_fetch) begin
          state_next = ST_FETCH;
        end else if (accept && go_find) begin
          state_next = ST_FIND;
        end
      end
      ST_FETCH: begin
        if (pend && pend_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIND: begin
        if (find_stop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    issue     = 1'b0;
    find_stop = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_FETCH: issue = (seq_left != '0);
      ST_FIND: begin
        find_stop = pend && (match || pend_last);
        issue     = (seq_left != '0) && !find_stop;
      end
      default: busy = 1'b1;
    endcase
  end

  brb_ram #(
    .DATA_W (BYTE_W),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wp),
    .wdata (data_byte),
    .re    (issue),
    .raddr (seq_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      fill      <= '0;
      burst_acc <= 1'b0;
      burst_rem <= '0;
      pend      <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (accept) begin
        wp        <= wp_next;
        rp        <= rp_next;
        fill      <= fill_next;
        burst_acc <= burst_acc_next;
        burst_rem <= burst_rem_next;
        strobe    <= imm_res;
      end
      pend <= issue;
      if (pend && state == ST_FETCH) begin
        strobe <= 1'b1;
      end
      if (find_stop) begin
        strobe <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_addr   <= load_addr;
      seq_left   <= load_left;
      seq_idx    <= '0;
      delim      <= data_byte;
      out_byte   <= '0;
      byte_valid <= 1'b0;
      ok         <= imm_ok;
      position   <= '0;
      available  <= fill_next;
      last       <= 1'b1;
    end
    if (issue) begin
      seq_addr  <= seq_addr + PTR_W'(1);
      seq_left  <= seq_left - CNT_W'(1);
      seq_idx   <= seq_idx + PTR_W'(1);
      pend_idx  <= seq_idx;
      pend_last <= (seq_left == CNT_W'(1));
    end
    if (pend && state == ST_FETCH) begin
      out_byte   <= rdata;
      byte_valid <= 1'b1;
      ok         <= 1'b0;
      position   <= '0;
      available  <= fill;
      last       <= pend_last;
    end
    if (find_stop) begin
      out_byte   <= '0;
      byte_valid <= 1'b0;
      ok         <= match;
      position   <= match ? pend_idx : '0;
      available  <= fill;
      last       <= 1'b1;
    end
  end

  `BRB_ASSERT_NOW(a_fill_bound, 1'b1, fill <= DepthC)
  `BRB_ASSERT_NOW(a_ptr_gap, 1'b1, PTR_W'(wp - rp) == fill[PTR_W-1:0])
  `BRB_ASSERT_NOW(a_burst_flag, burst_rem != '0, burst_acc)
  `BRB_ASSERT_NOW(a_pend_in_seq, pend, state != ST_IDLE)
  `BRB_ASSERT_NEXT(a_seq_result, state != ST_IDLE && state_next == ST_IDLE, strobe && last)

endmodule

// File: sim/byte_ring_buffer_with_search_test.sv
module byte_ring_buffer_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP   = 50;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [2:0]         op;
    logic [BYTE_W-1:0]  data;
    logic               first;
    logic [LEN_W-1:0]   len;
    logic [FETCH_W-1:0] fetch;
    logic [PTR_W-1:0]   off;
  } beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              ok;
    logic [PTR_W-1:0]  position;
    logic [CNT_W-1:0]  available;
    logic              last;
  } ring_result_t;

  // canned rows carry a single status result typed in by hand
  typedef struct packed {
    beat_t            cmd;
    logic             canned;
    logic             want_ok;
    logic [CNT_W-1:0] want_avail;
  } plan_row_t;

  localparam int PLAN_ROWS = 26;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{OP_READ,    8'h00, 1'b0, 13'd0,    7'd5,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_PEEK,    8'h00, 1'b0, 13'd0,    7'd3,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_FIND,    8'hAA, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_SPARE_7, 8'h00, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h11, 1'b1, 13'd4097, 7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h22, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h33, 1'b1, 13'd0,    7'd0,   12'd0},    1'b1, 1'b1, 13'd0},
    '{'{OP_WRITE,   8'hFF, 1'b1, 13'd4096, 7'd0,   12'd0},    1'b1, 1'b1, 13'd1},
    '{'{OP_WRITE,   8'h00, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b1, 13'd2},
    '{'{OP_WRITE,   8'h5A, 1'b0, 13'd0,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h81, 1'b1, 13'd3,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h7E, 1'b0, 13'd0,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h10, 1'b0, 13'd0,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h22, 1'b0, 13'd0,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_SPARE_6, 8'h00, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd6},
    '{'{OP_FIND,    8'h7E, 1'b0, 13'd0,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_PEEK,    8'h00, 1'b0, 13'd0,    7'd127, 12'd2},    1'b0, 1'b0, 13'd0},
    '{'{OP_PEEK,    8'h00, 1'b0, 13'd0,    7'd64,  12'd4095}, 1'b1, 1'b0, 13'd6},
    '{'{OP_PEEK,    8'h00, 1'b0, 13'd0,    7'd1,   12'd6},    1'b1, 1'b0, 13'd6},
    '{'{OP_READ,    8'h00, 1'b0, 13'd0,    7'd2,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_CONSUME, 8'h00, 1'b0, 13'd1,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_READ,    8'h00, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd3},
    '{'{OP_CONSUME, 8'h00, 1'b0, 13'd8191, 7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h44, 1'b1, 13'd5,    7'd0,   12'd0},    1'b0, 1'b0, 13'd0},
    '{'{OP_CLEAR,   8'h00, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd0},
    '{'{OP_WRITE,   8'h55, 1'b0, 13'd0,    7'd0,   12'd0},    1'b1, 1'b0, 13'd0}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic [BYTE_W-1:0]  data_byte;
  logic               burst_first;
  logic [LEN_W-1:0]   length;
  logic [FETCH_W-1:0] fetch_length;
  logic [PTR_W-1:0]   offset;
  logic               strobe;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic               ok;
  logic [PTR_W-1:0]   position;
  logic [CNT_W-1:0]   available;
  logic               last;

  byte_ring_buffer_with_search uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .burst_first  (burst_first),
    .length       (length),
    .fetch_length (fetch_length),
    .offset       (offset),
    .strobe       (strobe),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .ok           (ok),
    .position     (position),
    .available    (available),
    .last         (last)
  );

  // shadow copy of the ring
  logic [BYTE_W-1:0] shadow_bytes [DEPTH];
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  int unsigned       stored;
  bit                burst_open;
  int unsigned       burst_left;

  ring_result_t due_results[$];
  ring_result_t fresh[$];

  int unsigned errors;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned finds_sent;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report($sformatf("%s got %0h want %0h (result %0d)", name, got, want, results_seen));
  endtask

  function automatic ring_result_t status_only(input logic hit, input logic [PTR_W-1:0] pos);
    ring_result_t r;
    r = '0;
    r.ok = hit;
    r.position = pos;
    r.available = CNT_W'(stored);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int unsigned fetch_cap(input int unsigned req, input int unsigned have);
    int unsigned n;
    n = req;
    if (n > MAX_FETCH) n = MAX_FETCH;
    if (n > have) n = have;
    return n;
  endfunction

  function automatic logic take_byte(input logic [BYTE_W-1:0] b);
    if (!burst_open || burst_left == 0) return 1'b0;
    if (stored >= DEPTH) begin
      burst_open = 1'b0;
      burst_left = 0;
      return 1'b0;
    end
    shadow_bytes[tail_ptr] = b;
    tail_ptr = tail_ptr + 1'b1;
    stored++;
    burst_left--;
    return 1'b1;
  endfunction

  task automatic deliver(input logic [PTR_W-1:0] first_slot, input int unsigned n);
    ring_result_t r;
    if (n == 0) begin
      fresh.push_back(status_only(1'b0, '0));
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        r = '0;
        r.out_byte = shadow_bytes[first_slot + PTR_W'(i)];
        r.byte_valid = 1'b1;
        r.available = CNT_W'(stored);
        r.last = (i + 1 == n);
        fresh.push_back(r);
      end
    end
  endtask

  // work out the results of one beat and advance the shadow ring
  task automatic predict_ring(input beat_t c);
    int unsigned n;
    logic [PTR_W-1:0] p;
    logic hit;
    logic [PTR_W-1:0] spot;
    fresh.delete();
    hit = 1'b0;
    spot = '0;
    case (c.op)
      OP_WRITE: begin
        if (c.first) begin
          if (c.len <= DEPTH - stored) begin
            burst_open = 1'b1;
            burst_left = c.len;
            hit = 1'b1;
            if (c.len != 0) hit = take_byte(c.data);
          end else begin
            burst_open = 1'b0;
            burst_left = 0;
          end
        end else begin
          hit = take_byte(c.data);
        end
        fresh.push_back(status_only(hit, '0));
      end
      OP_READ: begin
        n = fetch_cap(c.fetch, stored);
        p = head_ptr;
        head_ptr = head_ptr + PTR_W'(n);
        stored -= n;
        deliver(p, n);
      end
      OP_PEEK: begin
        if (c.off >= stored) begin
          deliver('0, 0);
        end else begin
          n = fetch_cap(c.fetch, stored - c.off);
          deliver(head_ptr + c.off, n);
        end
      end
      OP_FIND: begin
        p = head_ptr;
        for (int unsigned i = 0; i < stored; i++) begin
          if (!hit && shadow_bytes[p] == c.data) begin
            hit = 1'b1;
            spot = PTR_W'(i);
          end
          p = p + 1'b1;
        end
        fresh.push_back(status_only(hit, spot));
      end
      OP_CONSUME: begin
        n = (c.len < stored) ? c.len : stored;
        head_ptr = head_ptr + PTR_W'(n);
        stored -= n;
        fresh.push_back(status_only(1'b0, '0));
      end
      OP_CLEAR: begin
        head_ptr = '0;
        tail_ptr = '0;
        stored = 0;
        burst_open = 1'b0;
        burst_left = 0;
        fresh.push_back(status_only(1'b0, '0));
      end
      default: begin
        fresh.push_back(status_only(1'b0, '0));
      end
    endcase
  endtask

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input beat_t c, input logic canned, input ring_result_t canned_res);
    opcode <= c.op;
    data_byte <= c.data;
    burst_first <= c.first;
    length <= c.len;
    fetch_length <= c.fetch;
    offset <= c.off;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_ring(c);
    if (canned) due_results.push_back(canned_res);
    else foreach (fresh[k]) due_results.push_back(fresh[k]);
    if (c.op == OP_FIND) finds_sent++;
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_idle(input int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic beat_t noise_beat(input logic [2:0] op);
    beat_t c;
    c.op = op;
    c.data = BYTE_W'($urandom);
    c.first = 1'($urandom);
    c.len = LEN_W'($urandom);
    c.fetch = FETCH_W'($urandom);
    c.off = PTR_W'($urandom);
    return c;
  endfunction

  task automatic random_phase(input int unsigned count, input int unsigned idle_pct);
    int unsigned goal;
    int unsigned pick;
    int unsigned blen;
    int unsigned follow;
    beat_t c;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 99);
      // hold the fill level down so finds stay short
      if (stored > 300 && pick < 40) pick = 40 + pick / 3;
      if (pick < 40) begin
        if ($urandom_range(0, 19) == 0) blen = $urandom_range(0, 8191);
        else if ($urandom_range(0, 9) == 0) blen = $urandom_range(0, 60);
        else blen = $urandom_range(1, 10);
        c = noise_beat(OP_WRITE);
        c.first = 1'b1;
        c.len = LEN_W'(blen);
        send_beat(c, 1'b0, '0);
        maybe_idle(idle_pct);
        follow = (blen > 64) ? $urandom_range(0, 3) : ((blen > 0) ? blen - 1 : 0);
        pick = $urandom_range(0, 99);
        if (pick < 8) follow = $urandom_range(0, follow);
        else if (pick < 14) follow++;
        repeat (follow) begin
          c = noise_beat(OP_WRITE);
          c.first = 1'b0;
          send_beat(c, 1'b0, '0);
          maybe_idle(idle_pct);
        end
      end else begin
        if (pick < 55) c = noise_beat(OP_READ);
        else if (pick < 67) c = noise_beat(OP_PEEK);
        else if (pick < 79) c = noise_beat(OP_FIND);
        else if (pick < 89) c = noise_beat(OP_CONSUME);
        else if (pick < 94) c = noise_beat(OP_WRITE);
        else if (pick < 97) c = noise_beat(OP_CLEAR);
        else c = noise_beat(pick[0] ? OP_SPARE_7 : OP_SPARE_6);
        if ($urandom_range(0, 9) != 0) c.fetch = FETCH_W'($urandom_range(0, MAX_FETCH));
        if (c.op == OP_PEEK && $urandom_range(0, 3) != 0)
          c.off = PTR_W'($urandom_range(0, stored + 2));
        if (c.op == OP_CONSUME && $urandom_range(0, 7) != 0)
          c.len = LEN_W'($urandom_range(0, 20));
        // aim most searches at a byte that is stored
        if (c.op == OP_FIND && stored > 0 && $urandom_range(0, 3) != 0)
          c.data = shadow_bytes[head_ptr + PTR_W'($urandom_range(0, stored - 1))];
        if (c.op == OP_WRITE) c.first = 1'b0;
        send_beat(c, 1'b0, '0);
        maybe_idle(idle_pct);
      end
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && strobe) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing pending: byte %0h valid %0b ok %0b",
                         out_byte, byte_valid, ok));
      end else begin
        want = due_results.pop_front();
        check_field("out_byte", out_byte, want.out_byte);
        check_field("byte_valid", byte_valid, want.byte_valid);
        check_field("ok", ok, want.ok);
        check_field("position", position, want.position);
        check_field("available", available, want.available);
        check_field("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    ring_result_t canned_res;
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    data_byte = '0;
    burst_first = 1'b0;
    length = '0;
    fetch_length = '0;
    offset = '0;
    head_ptr = '0;
    tail_ptr = '0;
    stored = 0;
    burst_open = 1'b0;
    burst_left = 0;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    finds_sent = 0;
    cycles = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      canned_res = '0;
      canned_res.ok = PLAN[r].want_ok;
      canned_res.available = PLAN[r].want_avail;
      canned_res.last = 1'b1;
      send_beat(PLAN[r].cmd, PLAN[r].canned, canned_res);
    end

    random_phase(110, 0);
    random_phase(110, 62);
    random_phase(110, 17);
    random_phase(30, 0);

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("drove %0d beats (%0d searches), checked %0d results, %0d mismatches",
             beats_sent, finds_sent, results_seen, errors);
    $display("covered bursts, stray bytes, reads, peeks, consumes, clears and sender gaps");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
